@@ design/assert_macros.svh @@
// Assertion helpers for the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent holds in the cycle of the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ecmu_pkg.sv @@
`default_nettype none

package ecmu_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_MOVE,
    ST_YAW,
    ST_WRAP,
    ST_CORD,
    ST_FMUL,
    ST_CROSS,
    ST_SQR,
    ST_SQRT,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_LOOK_SENS   = 3'd1;
  localparam logic [2:0] CFG_PLANAR_MODE = 3'd2;
  localparam logic [2:0] CFG_WORLD_UP_X  = 3'd3;
  localparam logic [2:0] CFG_WORLD_UP_Y  = 3'd4;
  localparam logic [2:0] CFG_WORLD_UP_Z  = 3'd5;

  // Operation and direction codes.
  localparam logic       OP_MOVE   = 1'b0;
  localparam logic       OP_LOOK   = 1'b1;
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Angles: yaw and pitch in 1/128 degree, CORDIC angles in 2^-15 degree.
  localparam logic [23:0]        YAW_FULL    = 24'd46080;
  localparam int                 PITCH_LIMIT = 11392;
  localparam logic signed [25:0] WRAP_BIAS   = 26'sd5898240;
  localparam logic signed [24:0] DEG90       = 25'sd2949120;
  localparam logic signed [24:0] DEG180      = 25'sd5898240;
  localparam logic signed [24:0] DEG270      = 25'sd8847360;
  localparam logic signed [24:0] DEG360      = 25'sd11796480;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

  // Reset values of the camera vectors, Q2.14.
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

  // Arctangent of 2^-i in 2^-15 degree units.
  function automatic logic [20:0] atan_val(input logic [3:0] i);
    logic [20:0] v;
    case (i)
      4'd0:    v = 21'd1474560;
      4'd1:    v = 21'd870484;
      4'd2:    v = 21'd459940;
      4'd3:    v = 21'd233473;
      4'd4:    v = 21'd117189;
      4'd5:    v = 21'd58652;
      4'd6:    v = 21'd29333;
      4'd7:    v = 21'd14667;
      4'd8:    v = 21'd7334;
      4'd9:    v = 21'd3667;
      4'd10:   v = 21'd1833;
      4'd11:   v = 21'd917;
      4'd12:   v = 21'd458;
      4'd13:   v = 21'd229;
      4'd14:   v = 21'd115;
      default: v = 21'd57;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/euler_camera_motion_update.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | operation, direction, frame_time, x/y offset
// out     | output    | out_valid / out_ready | pos_x/y/z, front_x/y/z, right_x/y/z
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is worked at a time by a sequencer around a single shared multiplier.
// A look does two 16-step CORDIC runs, two 32-step square roots and six 15-step
// divisions, all on the shared datapath.
// Reset is synchronous and needs no clearing pass; cfg writes are taken in any cycle.
// A finished result waits in the done state until the output register is free;
// no new transaction is accepted before the result has moved there.
`default_nettype none
`include "assert_macros.svh"

module euler_camera_motion_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [1:0]         in_direction,
  input  logic [15:0]        in_frame_time,
  input  logic signed [15:0] in_x_offset,
  input  logic signed [15:0] in_y_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers.
  logic [15:0]        move_speed_r;
  logic [15:0]        look_sens_r;
  logic               planar_r;
  logic signed [15:0] up_r [3];

  // Camera state.
  logic signed [31:0] pos_r   [3];
  logic [15:0]        yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];

  // Sequencer.
  ecmu_pkg::state_t state_r, state_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [1:0]       idx_r;
  logic             phase_r;
  logic             nz_r;
  logic             load_out;

  // Latched transaction.
  logic               op_r;
  logic [1:0]         dir_r;
  logic [15:0]        ft_r;
  logic signed [15:0] xoff_r;
  logic signed [15:0] yoff_r;

  // Scratch registers of the datapath.
  logic [31:0]        vel_r;
  logic signed [17:0] dvec_r [3];
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [33:0] xacc_r;
  logic [23:0]        wrap_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [24:0] cz_r;
  logic               cneg_r;
  logic signed [33:0] cosy_r, siny_r;
  logic signed [32:0] vec_r [3];
  logic [63:0]        sum_r, root_r;
  logic [31:0]        len_r;
  logic [46:0]        num_r;
  logic [13:0]        quo_r;
  logic signed [15:0] nrm_r [3];

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] opos_r   [3];
  logic signed [15:0] ofront_r [3];
  logic signed [15:0] oright_r [3];

  logic [1:0] lane;
  assign lane = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];

  // Cross product operand pairs: a x b, one product a cycle.
  logic [1:0]         ai, bi;
  logic signed [15:0] xa, xb;
  logic signed [33:0] x_diff;
  logic [1:0]         x_comp;
  logic signed [17:0] pln_d;

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      3'd5:    begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
  end

  assign xa     = (op_r == ecmu_pkg::OP_LOOK) ? front_r[ai] : up_r[ai];
  assign xb     = (op_r == ecmu_pkg::OP_LOOK) ? up_r[bi] : right_r[bi];
  assign x_diff = xacc_r - prod_r[33:0];
  assign x_comp = 2'(cnt_r[2:1] - 2'd1);
  assign pln_d  = 18'((x_diff + 34'sd8192) >>> 14);

  // Position step with rounding, sign and saturation.
  logic [1:0]         mv_p;
  logic signed [65:0] step_full;
  logic signed [28:0] step_v, step_s;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;

  assign mv_p      = 2'(cnt_r[1:0] - 2'd1);
  assign step_full = (prod_r + 66'sd2097152) >>> 22;
  assign step_v    = step_full[28:0];
  assign step_s    = (dir_r == ecmu_pkg::DIR_BACK || dir_r == ecmu_pkg::DIR_LEFT) ?
                     -step_v : step_v;
  assign pos_sum   = 34'(pos_r[mv_p]) + 34'(step_s);

  always_comb begin
    if (pos_sum > 34'sd2147483647) begin
      pos_sat = 32'sh7fffffff;
    end else if (pos_sum < -34'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // Angle deltas, yaw bias for the wrap and pitch saturation.
  logic signed [65:0] ang_full;
  logic signed [24:0] ang_d;
  logic signed [25:0] wrap_in;
  logic signed [25:0] pitch_sum;
  logic signed [14:0] pitch_sat;

  assign ang_full  = prod_r + 66'sd256;
  assign ang_d     = ang_full[33:9];
  assign wrap_in   = $signed({10'd0, yaw_r}) + 26'(ang_d) + ecmu_pkg::WRAP_BIAS;
  assign pitch_sum = 26'(pitch_r) + 26'(ang_d);

  always_comb begin
    if (pitch_sum > 26'(ecmu_pkg::PITCH_LIMIT)) begin
      pitch_sat = 15'(ecmu_pkg::PITCH_LIMIT);
    end else if (pitch_sum < -26'(ecmu_pkg::PITCH_LIMIT)) begin
      pitch_sat = -15'(ecmu_pkg::PITCH_LIMIT);
    end else begin
      pitch_sat = pitch_sum[14:0];
    end
  end

  // Modulo by the full turn: one conditional subtract a cycle.
  logic [2:0]  wk;
  logic [23:0] wsub, wrap_nxt;

  assign wk       = 3'(3'd7 - cnt_r[2:0]);
  assign wsub     = ecmu_pkg::YAW_FULL << wk;
  assign wrap_nxt = (wrap_r >= wsub) ? wrap_r - wsub : wrap_r;

  // CORDIC start angle, quadrant fold and one rotation step.
  logic signed [24:0] ang_in, ang_fold;
  logic               ang_neg;
  logic [3:0]         iter_i;
  logic signed [33:0] xs, ys;
  logic signed [24:0] at_v;
  logic signed [33:0] cp, sp;

  assign ang_in = (cnt_r == 6'd0) ? $signed({1'b0, yaw_r, 8'd0}) :
                  25'($signed({pitch_r, 8'd0}));

  always_comb begin
    if (ang_in > ecmu_pkg::DEG90 && ang_in <= ecmu_pkg::DEG270) begin
      ang_fold = ang_in - ecmu_pkg::DEG180;
      ang_neg  = 1'b1;
    end else if (ang_in > ecmu_pkg::DEG270) begin
      ang_fold = ang_in - ecmu_pkg::DEG360;
      ang_neg  = 1'b0;
    end else begin
      ang_fold = ang_in;
      ang_neg  = 1'b0;
    end
  end

  assign iter_i = (cnt_r <= 6'd16) ? 4'(cnt_r - 6'd1) : 4'(cnt_r - 6'd18);
  assign xs     = cx_r >>> iter_i;
  assign ys     = cy_r >>> iter_i;
  assign at_v   = $signed({4'd0, ecmu_pkg::atan_val(iter_i)});
  assign cp     = cneg_r ? -cx_r : cx_r;
  assign sp     = cneg_r ? -cy_r : cy_r;

  // Front components from the product of the two rotations.
  logic signed [65:0] fm_q;
  assign fm_q = prod_r >>> 30;

  // Sum of squares and one square root step.
  logic [63:0] sum_nxt, bitv, trial, root_nxt;
  logic        sq_ge;

  assign sum_nxt  = (cnt_r == 6'd1) ? prod_r[63:0] : sum_r + prod_r[63:0];
  assign bitv     = 64'd1 << (6'd62 - {cnt_r[4:0], 1'b0});
  assign trial    = root_r + bitv;
  assign sq_ge    = sum_r >= trial;
  assign root_nxt = sq_ge ? (root_r >> 1) + bitv : root_r >> 1;

  // One quotient bit of component / length.
  logic signed [32:0] dv_s, dv_abs;
  logic [46:0]        num_init, dsub;
  logic [3:0]         dk;
  logic               dge;
  logic [14:0]        q_fin;
  logic signed [15:0] q_sgn;

  assign dv_s     = vec_r[idx_r];
  assign dv_abs   = (dv_s < 0) ? -dv_s : dv_s;
  assign num_init = {1'b0, dv_abs[31:0], 14'd0} + 47'(len_r >> 1);
  assign dk       = 4'(6'd15 - cnt_r);
  assign dsub     = 47'(len_r) << dk;
  assign dge      = num_r >= dsub;
  assign q_fin    = {quo_r, dge};
  assign q_sgn    = (dv_s < 0) ? -16'(q_fin) : 16'(q_fin);

  // Operand select of the shared multiplier.
  always_comb begin
    case (state_r)
      ecmu_pkg::ST_VEL: begin
        mul_a = $signed({17'd0, move_speed_r});
        mul_b = $signed({17'd0, ft_r});
      end
      ecmu_pkg::ST_CROSS: begin
        mul_a = 33'(xa);
        mul_b = 33'(xb);
      end
      ecmu_pkg::ST_MOVE: begin
        mul_a = 33'(dvec_r[lane]);
        mul_b = $signed({1'b0, vel_r});
      end
      ecmu_pkg::ST_YAW: begin
        mul_a = (cnt_r == 6'd0) ? 33'(xoff_r) : 33'(yoff_r);
        mul_b = $signed({17'd0, look_sens_r});
      end
      ecmu_pkg::ST_FMUL: begin
        mul_a = (cnt_r == 6'd0) ? cosy_r[32:0] : siny_r[32:0];
        mul_b = cp[32:0];
      end
      ecmu_pkg::ST_SQR: begin
        mul_a = vec_r[lane];
        mul_b = vec_r[lane];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecmu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == ecmu_pkg::OP_LOOK) ? ecmu_pkg::ST_YAW :
                      ecmu_pkg::ST_VEL;
        end
      end
      ecmu_pkg::ST_VEL: begin
        if (cnt_r == 6'd1) begin
          if (dir_r == ecmu_pkg::DIR_LEFT || dir_r == ecmu_pkg::DIR_RIGHT || !planar_r) begin
            state_nxt = ecmu_pkg::ST_MOVE;
          end else begin
            state_nxt = ecmu_pkg::ST_CROSS;
          end
        end
      end
      ecmu_pkg::ST_CROSS: begin
        if (cnt_r == 6'd6) begin
          state_nxt = (op_r == ecmu_pkg::OP_LOOK) ? ecmu_pkg::ST_SQR : ecmu_pkg::ST_MOVE;
        end
      end
      ecmu_pkg::ST_MOVE: begin
        if (cnt_r == 6'd3) state_nxt = ecmu_pkg::ST_DONE;
      end
      ecmu_pkg::ST_YAW: begin
        if (cnt_r == 6'd2) state_nxt = ecmu_pkg::ST_WRAP;
      end
      ecmu_pkg::ST_WRAP: begin
        if (cnt_r == 6'd7) state_nxt = ecmu_pkg::ST_CORD;
      end
      ecmu_pkg::ST_CORD: begin
        if (cnt_r == 6'd34) state_nxt = ecmu_pkg::ST_FMUL;
      end
      ecmu_pkg::ST_FMUL: begin
        if (cnt_r == 6'd2) state_nxt = ecmu_pkg::ST_SQR;
      end
      ecmu_pkg::ST_SQR: begin
        if (cnt_r == 6'd3) begin
          state_nxt = (sum_nxt == 64'd0) ? ecmu_pkg::ST_NEXT : ecmu_pkg::ST_SQRT;
        end
      end
      ecmu_pkg::ST_SQRT: begin
        if (cnt_r == 6'd31) state_nxt = ecmu_pkg::ST_DIV;
      end
      ecmu_pkg::ST_DIV: begin
        if (cnt_r == 6'd15 && idx_r == 2'd2) state_nxt = ecmu_pkg::ST_NEXT;
      end
      ecmu_pkg::ST_NEXT: begin
        state_nxt = phase_r ? ecmu_pkg::ST_DONE : ecmu_pkg::ST_CROSS;
      end
      ecmu_pkg::ST_DONE: begin
        if (load_out) state_nxt = ecmu_pkg::ST_IDLE;
      end
      default: state_nxt = ecmu_pkg::ST_IDLE;
    endcase

    if (state_nxt != state_r || state_r == ecmu_pkg::ST_IDLE) begin
      cnt_nxt = '0;
    end else if (state_r == ecmu_pkg::ST_DIV && cnt_r == 6'd15) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == ecmu_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    load_out  = (state_r == ecmu_pkg::ST_DONE) && (!out_valid_r || out_ready);
  end

  // Control, configuration and camera state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ecmu_pkg::ST_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      move_speed_r <= 16'd640;
      look_sens_r  <= 16'd6554;
      planar_r     <= 1'b0;
      up_r[0]      <= '0;
      up_r[1]      <= ecmu_pkg::ONE_Q14;
      up_r[2]      <= '0;
      pos_r[0]     <= '0;
      pos_r[1]     <= '0;
      pos_r[2]     <= '0;
      yaw_r        <= 16'd34560;
      pitch_r      <= '0;
      front_r[0]   <= '0;
      front_r[1]   <= '0;
      front_r[2]   <= -ecmu_pkg::ONE_Q14;
      right_r[0]   <= ecmu_pkg::ONE_Q14;
      right_r[1]   <= '0;
      right_r[2]   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      // Configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          ecmu_pkg::CFG_MOVE_SPEED:  move_speed_r <= cfg_data;
          ecmu_pkg::CFG_LOOK_SENS:   look_sens_r  <= cfg_data;
          ecmu_pkg::CFG_PLANAR_MODE: planar_r     <= cfg_data[0];
          ecmu_pkg::CFG_WORLD_UP_X:  up_r[0]      <= cfg_data;
          ecmu_pkg::CFG_WORLD_UP_Y:  up_r[1]      <= cfg_data;
          ecmu_pkg::CFG_WORLD_UP_Z:  up_r[2]      <= cfg_data;
          default: ;
        endcase
      end

      // Output register.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ecmu_pkg::ST_IDLE: begin
          phase_r <= 1'b0;
          idx_r   <= '0;
        end
        ecmu_pkg::ST_MOVE: begin
          if (cnt_r != 6'd0) pos_r[mv_p] <= pos_sat;
        end
        ecmu_pkg::ST_YAW: begin
          if (cnt_r == 6'd2) pitch_r <= pitch_sat;
        end
        ecmu_pkg::ST_WRAP: begin
          if (cnt_r == 6'd7) yaw_r <= wrap_nxt[15:0];
        end
        ecmu_pkg::ST_DIV: begin
          if (cnt_r == 6'd15) idx_r <= (idx_r == 2'd2) ? 2'd0 : 2'(idx_r + 2'd1);
        end
        ecmu_pkg::ST_NEXT: begin
          // A zero length vector leaves the previous value in place.
          phase_r <= 1'b1;
          if (nz_r) begin
            if (!phase_r) begin
              front_r[0] <= nrm_r[0];
              front_r[1] <= nrm_r[1];
              front_r[2] <= nrm_r[2];
            end else begin
              right_r[0] <= nrm_r[0];
              right_r[1] <= nrm_r[1];
              right_r[2] <= nrm_r[2];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath scratch registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (load_out) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i]   <= pos_r[i];
        ofront_r[i] <= front_r[i];
        oright_r[i] <= right_r[i];
      end
    end

    case (state_r)
      ecmu_pkg::ST_IDLE: begin
        op_r   <= in_operation;
        dir_r  <= in_direction;
        ft_r   <= in_frame_time;
        xoff_r <= in_x_offset;
        yoff_r <= in_y_offset;
      end
      ecmu_pkg::ST_VEL: begin
        if (cnt_r == 6'd1) begin
          vel_r <= prod_r[31:0];
          for (int i = 0; i < 3; i++) begin
            dvec_r[i] <= (dir_r == ecmu_pkg::DIR_LEFT || dir_r == ecmu_pkg::DIR_RIGHT) ?
                         18'(right_r[i]) : 18'(front_r[i]);
          end
        end
      end
      ecmu_pkg::ST_CROSS: begin
        if (cnt_r[0]) begin
          xacc_r <= prod_r[33:0];
        end else if (cnt_r != 6'd0) begin
          if (op_r == ecmu_pkg::OP_LOOK) begin
            vec_r[x_comp] <= x_diff[32:0];
          end else begin
            dvec_r[x_comp] <= pln_d;
          end
        end
      end
      ecmu_pkg::ST_YAW: begin
        if (cnt_r == 6'd1) wrap_r <= wrap_in[23:0];
      end
      ecmu_pkg::ST_WRAP: begin
        wrap_r <= wrap_nxt;
      end
      ecmu_pkg::ST_CORD: begin
        if (cnt_r == 6'd0 || cnt_r == 6'd17) begin
          // Start a rotation; the second start also keeps the yaw result.
          if (cnt_r == 6'd17) begin
            cosy_r <= cp;
            siny_r <= sp;
          end
          cx_r   <= ecmu_pkg::CORDIC_K;
          cy_r   <= '0;
          cz_r   <= ang_fold;
          cneg_r <= ang_neg;
        end else if (cnt_r != 6'd34) begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at_v;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at_v;
          end
        end
      end
      ecmu_pkg::ST_FMUL: begin
        if (cnt_r == 6'd1) begin
          vec_r[0] <= fm_q[32:0];
          vec_r[1] <= sp[32:0];
        end else if (cnt_r == 6'd2) begin
          vec_r[2] <= fm_q[32:0];
        end
      end
      ecmu_pkg::ST_SQR: begin
        root_r <= '0;
        if (cnt_r != 6'd0) sum_r <= sum_nxt;
        if (cnt_r == 6'd3) nz_r <= (sum_nxt != 64'd0);
      end
      ecmu_pkg::ST_SQRT: begin
        if (sq_ge) sum_r <= sum_r - trial;
        root_r <= root_nxt;
        if (cnt_r == 6'd31) len_r <= root_nxt[31:0];
      end
      ecmu_pkg::ST_DIV: begin
        if (cnt_r == 6'd0) begin
          num_r <= num_init;
          quo_r <= '0;
        end else begin
          if (dge) num_r <= num_r - dsub;
          quo_r <= q_fin[13:0];
          if (cnt_r == 6'd15) nrm_r[idx_r] <= q_sgn;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = opos_r[0];
  assign out_pos_y   = opos_r[1];
  assign out_pos_z   = opos_r[2];
  assign out_front_x = ofront_r[0];
  assign out_front_y = ofront_r[1];
  assign out_front_z = ofront_r[2];
  assign out_right_x = oright_r[0];
  assign out_right_y = oright_r[1];
  assign out_right_z = oright_r[2];

  // Checks on the sequencer and the angle state.
  `ASSERT_ALWAYS(a_pitch_range, clk, rst_n, (pitch_r <= 15'sd11392) && (pitch_r >= -15'sd11392))
  `ASSERT_ALWAYS(a_yaw_range, clk, rst_n, yaw_r < 16'd46080)
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != ecmu_pkg::ST_IDLE)
  `ASSERT_NEXT(a_done_loads, clk, rst_n, load_out, out_valid && state_r == ecmu_pkg::ST_IDLE)

endmodule

`default_nettype wire
